// File: rtl/range_histogram_counter_defines.svh
// Assertion macros shared by the histogram RTL.
`ifndef RANGE_HISTOGRAM_COUNTER_DEFINES_SVH
`define RANGE_HISTOGRAM_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rhc_pkg.sv
// Types and constants shared by the histogram modules.
package rhc_pkg;

	localparam int BIN_W     = 7;            // class_count range caps the bin index
	localparam int BIN_LIMIT = 1 << BIN_W;   // bins that can ever be addressed

	typedef logic signed [15:0] sample_t;
	typedef logic [1:0]         cat_t;
	typedef logic [1:0]         cfg_idx_t;
	typedef logic [23:0]        cfg_data_t;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam cat_t CAT_IN_RANGE = 2'd0;
	localparam cat_t CAT_UNDER    = 2'd1;
	localparam cat_t CAT_OVER     = 2'd2;
	localparam cat_t CAT_READ     = 2'd3;

	localparam cfg_idx_t CFG_LOW_BOUND   = 2'd0;
	localparam cfg_idx_t CFG_HIGH_BOUND  = 2'd1;
	localparam cfg_idx_t CFG_CLASS_COUNT = 2'd2;
	localparam cfg_idx_t CFG_BIN_SCALE   = 2'd3;

	// Classification of one request, handed from the binning logic to the count stage.
	typedef struct packed {
		cat_t             cat;
		logic [BIN_W-1:0] bin;
		logic             in_store;   // read_bin lies inside the stored bins
	} cls_t;

endpackage

// File: rtl/rhc_bin_calc.sv
// Classifies one request and computes the target bin.
module rhc_bin_calc #(
	parameter int MEM_DEPTH = 64
) (
	input  logic            req_type,
	input  rhc_pkg::sample_t sample,
	input  logic [5:0]      read_bin,
	input  rhc_pkg::sample_t low_bound,
	input  rhc_pkg::sample_t high_bound,
	input  logic [6:0]      class_count,
	input  logic [23:0]     bin_scale,
	output rhc_pkg::cls_t   cls
);
	import rhc_pkg::*;

	localparam logic [7:0] DEPTH_L = 8'(MEM_DEPTH);

	logic              below;
	logic              above;
	logic signed [16:0] diff_w;
	logic [15:0]       diff;
	logic [39:0]       prod;
	logic [23:0]       quot;
	logic [7:0]        used;
	logic [7:0]        used_m1;
	logic [BIN_W-1:0]  bin;

	assign below  = sample < low_bound;
	assign above  = sample > high_bound;
	assign diff_w = {sample[15], sample} - {low_bound[15], low_bound};
	assign diff   = diff_w[15:0];   // never negative when in range
	assign prod   = {24'd0, diff} * {16'd0, bin_scale};
	assign quot   = prod[39:16];

	always_comb begin
		if (class_count == 7'd0) begin
			used = 8'd1;
		end else if ({1'b0, class_count} > DEPTH_L) begin
			used = DEPTH_L;
		end else begin
			used = {1'b0, class_count};
		end
		used_m1 = used - 8'd1;
		if (quot > {16'd0, used_m1}) begin
			bin = used_m1[BIN_W-1:0];
		end else begin
			bin = quot[BIN_W-1:0];
		end
	end

	always_comb begin
		cls.bin      = '0;
		cls.in_store = 1'b1;
		if (req_type == REQ_READ) begin
			cls.cat      = CAT_READ;
			cls.bin      = {1'b0, read_bin};
			cls.in_store = {2'b00, read_bin} < DEPTH_L;
		end else if (below) begin
			cls.cat = CAT_UNDER;
		end else if (above) begin
			cls.cat = CAT_OVER;
		end else begin
			cls.cat = CAT_IN_RANGE;
			cls.bin = bin;
		end
	end

endmodule

// File: rtl/rhc_count_mem.sv
// Bin counter memory with per-entry valid bits and write forwarding.
module rhc_count_mem #(
	parameter int MEM_DEPTH   = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MEM_DEPTH)-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MEM_DEPTH)-1:0] wr_addr,
	input  logic [COUNT_WIDTH-1:0]       wr_data,
	output logic [COUNT_WIDTH-1:0]       rd_value
);
	logic [COUNT_WIDTH-1:0] mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]   vbit_q;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic                   rd_vld_q;
	logic                   fwd_hit_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q    <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vbit_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= vbit_q[rd_addr];
				// write landing on the same edge as the read: the array returns old data
				fwd_hit_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_comb begin
		if (fwd_hit_q) begin
			rd_value = fwd_data_q;
		end else if (rd_vld_q) begin
			rd_value = rd_data_q;
		end else begin
			rd_value = '0;
		end
	end

endmodule

// File: rtl/range_histogram_counter.sv
// Fixed-range histogram with underflow, overflow and total counters.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, req_type, sample, read_bin  | sink
//  out     | out_valid, out_ready, category, bin_index,      | source
//          | bin_count, underflow_count, overflow_count,     |
//          | total_count                                     |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | sink
//
// One beat per cycle in and out while out_ready holds. A result reaches the output
// register through stages s1 and s2 after the edge that accepts its beat.
// Rate is set by the bin counter memory: one read-modify-write per cycle while s2
// advances, with the previous write forwarded into the count stage.
// Reset clears the counters and the per-entry valid bits at once; no clearing pass.
// Each stage moves whenever the one after it is empty or moving, so a stalled output
// still lets beats fill the empty stages ahead of it.
`include "range_histogram_counter_defines.svh"

module range_histogram_counter #(
	parameter int NUM_BINS    = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  rhc_pkg::sample_t   sample,
	input  logic [5:0]         read_bin,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output rhc_pkg::cat_t      category,
	output logic [5:0]         bin_index,
	output logic [31:0]        bin_count,
	output logic [31:0]        underflow_count,
	output logic [31:0]        overflow_count,
	output logic [31:0]        total_count,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  rhc_pkg::cfg_idx_t  cfg_index,
	input  rhc_pkg::cfg_data_t cfg_data
);
	import rhc_pkg::*;

	// class_count tops out below BIN_LIMIT, so bins beyond it are never touched
	localparam int MEM_DEPTH = (NUM_BINS < BIN_LIMIT) ? NUM_BINS : BIN_LIMIT;
	localparam int AW        = $clog2(MEM_DEPTH);

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	function automatic logic [31:0] low32(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w     = 64'(v);
		low32 = w[31:0];
	endfunction

	// configuration registers
	sample_t    low_bound_q;
	sample_t    high_bound_q;
	logic [6:0] class_count_q;
	logic [23:0] bin_scale_q;

	// stage s1: input register
	logic       vld_s1;
	logic       req_s1;
	sample_t    sample_s1;
	logic [5:0] read_bin_s1;

	// stage s2: classified request, memory read in flight
	logic       vld_s2;
	cls_t       cls_s1;
	cls_t       cls_s2;

	// output register
	logic       vld_s3;

	// counters
	logic [COUNT_WIDTH-1:0] below_q;
	logic [COUNT_WIDTH-1:0] above_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] below_nx;
	logic [COUNT_WIDTH-1:0] above_nx;
	logic [COUNT_WIDTH-1:0] total_nx;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [COUNT_WIDTH-1:0] new_cnt;
	logic [COUNT_WIDTH-1:0] res_cnt;

	logic en_s1;
	logic en_s2;
	logic en_s3;
	logic adv_s2;
	logic mem_wr_en;

	// ---------------- handshake and stage enables ----------------
	assign en_s3     = !vld_s3 || out_ready;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign adv_s2    = vld_s2 && en_s3;
	assign in_ready  = en_s1;
	assign out_valid = vld_s3;
	assign cfg_ready = 1'b1;

	// ---------------- register writes ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q   <= 16'sd0;
			high_bound_q  <= 16'sd32767;
			class_count_q <= 7'd64;
			bin_scale_q   <= 24'd2048;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOW_BOUND:   low_bound_q   <= cfg_data[15:0];
				CFG_HIGH_BOUND:  high_bound_q  <= cfg_data[15:0];
				CFG_CLASS_COUNT: class_count_q <= cfg_data[6:0];
				CFG_BIN_SCALE:   bin_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage s1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			req_s1      <= req_type;
			sample_s1   <= sample;
			read_bin_s1 <= read_bin;
		end
	end

	// compare, subtract, scale and clamp: result addresses the counter memory
	rhc_bin_calc #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_bin_calc (
		.req_type   (req_s1),
		.sample     (sample_s1),
		.read_bin   (read_bin_s1),
		.low_bound  (low_bound_q),
		.high_bound (high_bound_q),
		.class_count(class_count_q),
		.bin_scale  (bin_scale_q),
		.cls        (cls_s1)
	);

	// ---------------- stage s2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cls_s2 <= cls_s1;
		end
	end

	assign mem_wr_en = adv_s2 && (cls_s2.cat == CAT_IN_RANGE);

	// memory read is issued from s1 and lands with the item in s2
	rhc_count_mem #(
		.MEM_DEPTH  (MEM_DEPTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en_s2),
		.rd_addr (cls_s1.bin[AW-1:0]),
		.wr_en   (mem_wr_en),
		.wr_addr (cls_s2.bin[AW-1:0]),
		.wr_data (new_cnt),
		.rd_value(cur_cnt)
	);

	assign new_cnt = sat_inc(cur_cnt);

	always_comb begin
		below_nx = below_q;
		above_nx = above_q;
		total_nx = sat_inc(total_q);
		res_cnt  = '0;
		case (cls_s2.cat)
			CAT_IN_RANGE: res_cnt = new_cnt;
			CAT_UNDER:    below_nx = sat_inc(below_q);
			CAT_OVER:     above_nx = sat_inc(above_q);
			CAT_READ: begin
				total_nx = total_q;   // reads leave every counter alone
				res_cnt  = cls_s2.in_store ? cur_cnt : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_q <= '0;
			above_q <= '0;
			total_q <= '0;
		end else if (adv_s2) begin
			below_q <= below_nx;
			above_q <= above_nx;
			total_q <= total_nx;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			category        <= cls_s2.cat;
			bin_index       <= cls_s2.bin[5:0];
			bin_count       <= low32(res_cnt);
			underflow_count <= low32(below_nx);
			overflow_count  <= low32(above_nx);
			total_count     <= low32(total_nx);
		end
	end

	// ---------------- assertions ----------------
	`RHC_ASSERT_NOW(a_ready_only_when_full, !in_ready, vld_s1 && vld_s2 && vld_s3,
		"input stalled while a stage is empty")
	`RHC_ASSERT_NOW(a_out_of_range_zero,
		out_valid && (category == CAT_UNDER || category == CAT_OVER),
		bin_index == 6'd0 && bin_count == 32'd0,
		"underflow or overflow beat carries a bin")
	`RHC_ASSERT_NEXT(a_read_keeps_counters, adv_s2 && (cls_s2.cat == CAT_READ),
		$stable(below_q) && $stable(above_q) && $stable(total_q),
		"read request changed a counter")
	`RHC_ASSERT_NEXT(a_total_after_add, adv_s2 && (cls_s2.cat != CAT_READ),
		total_q != '0, "total counter zero after an add")

endmodule

// File: dv/tb_range_histogram_counter.sv
// Self-checking testbench for range_histogram_counter: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module tb_range_histogram_counter;
	import rhc_pkg::*;

	localparam int NUM_BINS        = 64;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int RANDOM_PHASES   = 19;      // about 1900 random requests in all
	localparam int LONG_HOLD       = 400;     // receiver hold-off, long enough to back up the pipe
	localparam int DRAIN_CYCLES    = 20;      // well past the result path through s1, s2 and the output register
	localparam int CYCLE_LIMIT     = 200000;  // watchdog bound on the whole run

	// One result beat as the output ports carry it.
	typedef struct packed {
		cat_t        cat;
		logic [5:0]  idx;
		logic [31:0] cnt;
		logic [31:0] under;
		logic [31:0] over;
		logic [31:0] total;
	} result_beat_t;

	// Histogram predictor plus the queue of results still owed by the block.
	class histogram_scoreboard;
		logic [31:0]  bin_counts [NUM_BINS];
		logic [31:0]  below_seen;
		logic [31:0]  above_seen;
		logic [31:0]  adds_seen;
		sample_t      low_bound;
		sample_t      high_bound;
		logic [6:0]   class_count;
		logic [23:0]  bin_scale;
		result_beat_t awaited_results [$];
		int           errors;
		int           checked;
		int           reg_writes;
		int           cat_hits [4];

		function new();
			foreach (bin_counts[i]) bin_counts[i] = '0;
			foreach (cat_hits[i]) cat_hits[i] = 0;
			below_seen  = '0;
			above_seen  = '0;
			adds_seen   = '0;
			low_bound   = 16'sd0;
			high_bound  = 16'sd32767;
			class_count = 7'd64;
			bin_scale   = 24'd2048;
			errors      = 0;
			checked     = 0;
			reg_writes  = 0;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		// Bin of an in-range sample: exact product, truncated, clamped to the last bin in use.
		function logic [5:0] bin_for(sample_t s);
			int          d;
			logic [16:0] diff;
			logic [40:0] prod;
			logic [24:0] raw;
			logic [6:0]  used;
			d    = s - low_bound;
			diff = d[16:0];
			prod = diff * bin_scale;
			raw  = prod[40:16];
			if (class_count == 7'd0)
				used = 7'd1;
			else if (class_count > 7'(NUM_BINS))
				used = 7'(NUM_BINS);
			else
				used = class_count;
			if (raw > 25'(used - 7'd1))
				raw = 25'(used - 7'd1);
			return raw[5:0];
		endfunction

		task write_reg(cfg_idx_t index, cfg_data_t data);
			reg_writes++;
			case (index)
				CFG_LOW_BOUND:   low_bound   = data[15:0];
				CFG_HIGH_BOUND:  high_bound  = data[15:0];
				CFG_CLASS_COUNT: class_count = data[6:0];
				CFG_BIN_SCALE:   bin_scale   = data;
				default: ;
			endcase
		endtask

		task note_request(logic kind, sample_t s, logic [5:0] rbin);
			result_beat_t want;
			want = '0;
			if (kind == REQ_READ) begin
				want.cat = CAT_READ;
				want.idx = rbin;
				want.cnt = bin_counts[rbin];
			end else begin
				// low test first, so crossed bounds never reach the binning
				if (s < low_bound) begin
					below_seen = bump(below_seen);
					want.cat   = CAT_UNDER;
				end else if (s > high_bound) begin
					above_seen = bump(above_seen);
					want.cat   = CAT_OVER;
				end else begin
					want.idx            = bin_for(s);
					bin_counts[want.idx] = bump(bin_counts[want.idx]);
					want.cnt            = bin_counts[want.idx];
					want.cat            = CAT_IN_RANGE;
				end
				adds_seen = bump(adds_seen);
			end
			want.under = below_seen;
			want.over  = above_seen;
			want.total = adds_seen;
			cat_hits[want.cat]++;
			awaited_results.push_back(want);
		endtask

		task report(string msg);
			if (errors < 40)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(result_beat_t got);
			result_beat_t want;
			checked++;
			if (awaited_results.size() == 0) begin
				report($sformatf("result beat %0d arrived with no request outstanding", checked));
				return;
			end
			want = awaited_results.pop_front();
			if (got.cat !== want.cat)
				report($sformatf("beat %0d category %0d, want %0d", checked, got.cat, want.cat));
			if (got.idx !== want.idx)
				report($sformatf("beat %0d bin_index %0d, want %0d", checked, got.idx, want.idx));
			if (got.cnt !== want.cnt)
				report($sformatf("beat %0d bin_count %0d, want %0d", checked, got.cnt, want.cnt));
			if (got.under !== want.under)
				report($sformatf("beat %0d underflow_count %0d, want %0d",
					checked, got.under, want.under));
			if (got.over !== want.over)
				report($sformatf("beat %0d overflow_count %0d, want %0d",
					checked, got.over, want.over));
			if (got.total !== want.total)
				report($sformatf("beat %0d total_count %0d, want %0d",
					checked, got.total, want.total));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	sample_t     sample;
	logic [5:0]  read_bin;
	logic        out_valid;
	logic        out_ready;
	cat_t        category;
	logic [5:0]  bin_index;
	logic [31:0] bin_count;
	logic [31:0] underflow_count;
	logic [31:0] overflow_count;
	logic [31:0] total_count;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	cfg_data_t   cfg_data;

	histogram_scoreboard sb = new();

	int          in_stall_pct  = 6;   // chance per cycle that the sender holds back
	int          out_stall_pct = 45;  // chance per cycle that the receiver is not ready
	int          holds_asked   = 0;   // written by the stimulus only
	int          holds_done    = 0;   // written by the receiver only
	int          settings_loaded = 0;
	int          cur_lo;              // window of the current settings, for sample picking
	int          cur_hi;
	int unsigned cycles = 0;

	range_histogram_counter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.sample          (sample),
		.read_bin        (read_bin),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.category        (category),
		.bin_index       (bin_index),
		.bin_count       (bin_count),
		.underflow_count (underflow_count),
		.overflow_count  (overflow_count),
		.total_count     (total_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, plus a long hold-off whenever the stimulus asks.
	// The hold is counted here so the sender keeps pushing beats while the pipe fills.
	initial begin : receiver
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= out_stall_pct);
			end
		end
	end

	// Monitors sample pre-edge values. Output is checked before the input is noted;
	// a beat accepted now is still in s1, so it never answers on this edge anyway.
	always @(posedge clk) begin
		result_beat_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {category, bin_index, bin_count, underflow_count,
					overflow_count, total_count};
				sb.check_result(got);
			end
			if (in_valid && in_ready)
				sb.note_request(req_type, sample, read_bin);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout: %0d cycles, %0d results still owed", cycles, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Present one request beat and hold it until accepted. Called at a clock edge.
	task send_req(logic kind, sample_t s, logic [5:0] rbin);
		in_valid <= 1'b1;
		req_type <= kind;
		sample   <= s;
		read_bin <= rbin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Same, with the sender's random idle cycles ahead of the beat.
	task offer(logic kind, sample_t s, logic [5:0] rbin);
		while ($urandom_range(99) < in_stall_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		send_req(kind, s, rbin);
	endtask

	// Stop sending and wait until every owed result has come back.
	// The accepting edge goes by first: the monitor may not have noted the last beat on it yet.
	task close_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write all four registers back to back; only called while the block is idle.
	// Bits above a register's width are don't-care and sometimes carry noise.
	task load_ranges(sample_t lo, sample_t hi, logic [6:0] cc, logic [23:0] sc);
		cfg_idx_t  regs [4];
		cfg_data_t words [4];
		int        i;
		regs[0]  = CFG_LOW_BOUND;
		regs[1]  = CFG_HIGH_BOUND;
		regs[2]  = CFG_CLASS_COUNT;
		regs[3]  = CFG_BIN_SCALE;
		words[0] = {{8{lo[15]}}, lo};
		words[1] = {{8{hi[15]}}, hi};
		words[2] = {17'd0, cc};
		words[3] = sc;
		if ($urandom_range(9) == 0) words[0][23:16] = 8'($urandom);
		if ($urandom_range(9) == 0) words[1][23:16] = 8'($urandom);
		if ($urandom_range(9) == 0) words[2][23:7]  = 17'($urandom);
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= words[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// New random settings: mostly a narrow window with a matching scale, sometimes the
	// full range, a single-value window, crossed bounds, odd bin counts or wild scales.
	task pick_ranges();
		int         lo;
		int         hi;
		int         span;
		int         used;
		logic [6:0] cc;
		logic [23:0] sc;
		lo = int'($urandom_range(65535)) - 32768;
		hi = lo + int'($urandom_range(3000));
		if (hi > 32767) hi = 32767;
		case ($urandom_range(7))
			0: begin
				lo = -32768;
				hi = 32767;
			end
			1: begin
				lo = int'($urandom_range(32767));
				hi = lo - 1 - int'($urandom_range(500));
			end
			2: hi = lo;
			default: ;
		endcase
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: cc = 7'd0;
				1: cc = 7'd1;
				2: cc = 7'd127;
				default: cc = 7'($urandom_range(65, 126));
			endcase
		end else begin
			cc = 7'($urandom_range(1, 64));
		end
		used = (cc == 7'd0) ? 1 : (cc > 7'(NUM_BINS)) ? NUM_BINS : int'(cc);
		span = hi - lo + 1;
		if (span < 1) span = 1;
		case ($urandom_range(19))
			0, 1, 2:  sc = 24'($urandom);
			3:        sc = 24'd0;
			4:        sc = 24'hFF_FFFF;
			default:  sc = 24'((used * 65536) / span + int'($urandom_range(3)));
		endcase
		cur_lo = lo;
		cur_hi = hi;
		load_ranges(16'(lo), 16'(hi), cc, sc);
	endtask

	// Mostly inside the window, then its edges and one step past them, then anything.
	function sample_t pick_sample();
		int v;
		int r;
		r = $urandom_range(99);
		if (r < 60 && cur_lo <= cur_hi)
			v = cur_lo + int'($urandom_range(cur_hi - cur_lo));
		else if (r < 82) begin
			case ($urandom_range(3))
				0: v = cur_lo - 1;
				1: v = cur_lo;
				2: v = cur_hi;
				default: v = cur_hi + 1;
			endcase
		end else
			v = int'($urandom);
		return v[15:0];
	endfunction

	task offer_random();
		if ($urandom_range(4) == 0)
			offer(REQ_READ, 16'($urandom), 6'($urandom));
		else
			offer(REQ_ADD, pick_sample(), 6'($urandom));
	endtask

	initial begin : stimulus
		int p;
		in_valid  = 1'b0;
		req_type  = REQ_ADD;
		sample    = '0;
		read_bin  = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LOW_BOUND;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: window 0..max, 64 bins. Top of range clamps into the last bin.
		offer(REQ_ADD, 16'sd0, 6'($urandom));
		offer(REQ_ADD, 16'sd32767, 6'($urandom));
		offer(REQ_ADD, -16'sd1, 6'($urandom));
		offer(REQ_ADD, -16'sd32768, 6'($urandom));
		offer(REQ_READ, 16'($urandom), 6'd0);
		offer(REQ_READ, 16'($urandom), 6'd63);
		close_phase();

		// Window -1.0..+1.0 in 8 bins: both bounds, one step outside each, one inside the top, the middle.
		load_ranges(-16'sd256, 16'sd256, 7'd8, 24'd1024);
		offer(REQ_ADD, -16'sd257, 6'($urandom));
		offer(REQ_ADD, 16'sd257, 6'($urandom));
		offer(REQ_ADD, -16'sd256, 6'($urandom));
		offer(REQ_ADD, 16'sd256, 6'($urandom));
		offer(REQ_ADD, 16'sd255, 6'($urandom));
		offer(REQ_ADD, 16'sd0, 6'($urandom));
		offer(REQ_READ, 16'($urandom), 6'd7);
		close_phase();

		// Crossed bounds: nothing is ever in range.
		load_ranges(16'sd100, -16'sd100, 7'd0, 24'hFF_FFFF);
		offer(REQ_ADD, 16'sd0, 6'($urandom));
		offer(REQ_ADD, 16'sd200, 6'($urandom));
		offer(REQ_ADD, -16'sd200, 6'($urandom));
		close_phase();

		// Full range with zero bins requested: everything lands in bin 0.
		load_ranges(-16'sd32768, 16'sd32767, 7'd0, 24'hFF_FFFF);
		offer(REQ_ADD, 16'sd32767, 6'($urandom));
		offer(REQ_ADD, -16'sd32768, 6'($urandom));
		close_phase();

		// Bin count above the store: clamps to the last stored bin; read of that bin.
		load_ranges(-16'sd32768, 16'sd32767, 7'd127, 24'hFF_FFFF);
		offer(REQ_ADD, 16'sd32767, 6'($urandom));
		offer(REQ_ADD, 16'sd0, 6'($urandom));
		offer(REQ_READ, 16'($urandom), 6'd63);
		close_phase();

		// Random phases: a third with a sluggish receiver, a third with a sluggish
		// sender, then full rate both ways. Two phases open with a long hold-off.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			in_stall_pct  = (p < 6) ? 6 : (p < 12) ? 45 : 0;
			out_stall_pct = (p < 6) ? 45 : (p < 12) ? 6 : 0;
			pick_ranges();
			if (p == 2 || p == 13)
				holds_asked++;
			repeat (ITEMS_PER_PHASE) offer_random();
			close_phase();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d binned, %0d underflow, %0d overflow, %0d reads",
			sb.checked, sb.cat_hits[CAT_IN_RANGE], sb.cat_hits[CAT_UNDER],
			sb.cat_hits[CAT_OVER], sb.cat_hits[CAT_READ]);
		$display("%0d register writes over %0d settings, %0d long output hold-offs, %0d cycles",
			sb.reg_writes, settings_loaded, holds_done, cycles);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_bin_calc.sv
rtl/rhc_count_mem.sv
rtl/range_histogram_counter.sv
dv/tb_range_histogram_counter.sv
